// ===== src/denomination_tally_table_core_assert.svh =====
// Assertion macros for the checker of the tally table core.
// Both sample on the rising edge of clk and are switched off while rst_n is low.
`ifndef DENOMINATION_TALLY_TABLE_CORE_ASSERT_SVH
`define DENOMINATION_TALLY_TABLE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dtt_pkg.sv =====
`timescale 1ns / 1ps

package dtt_pkg;

  // Table geometry: entries are spread over the search lanes, entry i living in
  // lane i % LANES at bank address i / LANES.
  localparam int MAX_ENTRIES = 16;
  localparam int LANES       = 4;
  localparam int LANE_W      = 2;
  localparam int STEPS       = (MAX_ENTRIES + LANES - 1) / LANES;
  localparam int STEP_W      = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int GI_W        = STEP_W + LANE_W;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W       = (GI_W > CNT_W) ? GI_W : CNT_W;

  // Field widths.
  localparam int LEN_W    = 8;
  localparam int DCH_W    = 64;
  localparam int PCH_W    = 24;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 4;
  localparam int DENOM_W  = 27;
  localparam int PCS_W    = 10;
  localparam int COUNT_W  = 16;
  localparam int AMOUNT_W = 43;

  // Character counts of the two ASCII fields.
  localparam int DENOM_CHARS = 8;
  localparam int PCS_CHARS   = 3;

  // Input request packing, lowest bit first.
  localparam int IN_LEN_LSB = 0;
  localparam int IN_DCH_LSB = IN_LEN_LSB + LEN_W;
  localparam int IN_PCH_LSB = IN_DCH_LSB + DCH_W;
  localparam int IN_W       = IN_PCH_LSB + PCH_W;

  // Result packing, lowest bit first, padded to whole bytes.
  localparam int OUT_IDX_LSB = 0;
  localparam int OUT_DEN_LSB = OUT_IDX_LSB + INDEX_W;
  localparam int OUT_CNT_LSB = OUT_DEN_LSB + DENOM_W;
  localparam int OUT_AMT_LSB = OUT_CNT_LSB + COUNT_W;
  localparam int OUT_SAT_BIT = OUT_AMT_LSB + AMOUNT_W;
  localparam int OUT_REJ_BIT = OUT_SAT_BIT + 1;
  localparam int OUT_USED    = OUT_REJ_BIT + 1;
  localparam int OUT_W       = ((OUT_USED + 7) / 8) * 8;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_START     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_END       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TALLIED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MALFORMED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

  // Character and frame constants.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [LEN_W-1:0] MIN_LEN = 8'd15;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Running state of the digit-serial decimal parser.
  typedef struct packed {
    logic [DENOM_W-1:0] acc;
    logic               seen;
    logic               trailer;
    logic               bad;
  } parse_t;

  // One table entry seen by a lane in the current search step.
  typedef struct packed {
    logic               hit;
    logic [COUNT_W-1:0] count;
  } lane_res_t;

  // Write request towards one lane's bank.
  typedef struct packed {
    logic               en;
    logic [STEP_W-1:0]  addr;
    logic [DENOM_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } lane_wr_t;

  // Outcome of one search step after merging the lanes.
  typedef struct packed {
    logic               found;
    logic [GI_W-1:0]    slot;
    logic [COUNT_W-1:0] count;
  } merge_res_t;

  // Consumes one character: padding before the digits, digits, then padding only.
  function automatic parse_t parse_step(parse_t s, logic [7:0] ch);
    parse_t r;
    r = s;
    if (ch inside {[CH_0:CH_9]}) begin
      if (s.trailer) begin
        r.bad = 1'b1;
      end
      r.acc  = DENOM_W'({s.acc, 3'b000}) + DENOM_W'({s.acc, 1'b0}) + DENOM_W'(ch - CH_0);
      r.seen = 1'b1;
    end else if (ch == CH_SPACE || ch == CH_NUL) begin
      if (s.seen) begin
        r.trailer = 1'b1;
      end
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== src/dtt_lane.sv =====
`timescale 1ns / 1ps

module dtt_lane (
  input  logic                           clk,
  input  logic [dtt_pkg::STEP_W-1:0]     rd_addr,
  input  logic [dtt_pkg::DENOM_W-1:0]    key,
  input  dtt_pkg::lane_wr_t              wr,
  output dtt_pkg::lane_res_t             res
);

  // This lane's share of the table.
  logic [dtt_pkg::DENOM_W-1:0] val_mem [dtt_pkg::STEPS];
  logic [dtt_pkg::COUNT_W-1:0] cnt_mem [dtt_pkg::STEPS];
  logic [dtt_pkg::DENOM_W-1:0] rd_value_r;
  logic [dtt_pkg::COUNT_W-1:0] rd_count_r;

  // Single write port, registered read.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      val_mem[wr.addr] <= wr.value;
      cnt_mem[wr.addr] <= wr.count;
    end
    rd_value_r <= val_mem[rd_addr];
    rd_count_r <= cnt_mem[rd_addr];
  end

  // Compare the entry read last cycle against the denomination being looked up.
  assign res.hit   = (rd_value_r == key);
  assign res.count = rd_count_r;

endmodule

// ===== src/dtt_merge.sv =====
`timescale 1ns / 1ps

module dtt_merge (
  input  dtt_pkg::lane_res_t           res [dtt_pkg::LANES],
  input  logic [dtt_pkg::STEP_W-1:0]   step,
  input  logic [dtt_pkg::CNT_W-1:0]    entries_used,
  output dtt_pkg::merge_res_t          mres
);

  logic [dtt_pkg::GI_W-1:0] gidx;

  // Keep the lowest lane whose entry is in use and matches.
  always_comb begin
    mres = '0;
    gidx = '0;
    for (int l = dtt_pkg::LANES - 1; l >= 0; l--) begin
      gidx = {step, dtt_pkg::LANE_W'(l)};
      if (res[l].hit &&
          (dtt_pkg::CMP_W'(gidx) < dtt_pkg::CMP_W'(entries_used))) begin
        mres.found = 1'b1;
        mres.slot  = gidx;
        mres.count = res[l].count;
      end
    end
  end

endmodule

// ===== src/denomination_tally_table_core.sv =====
`timescale 1ns / 1ps
// Denomination tally table.
// in_t* carries one reply frame per request: frame length, the eight-character
// denomination field and the three-character piece-count field.
// out_t* returns one result per frame: status in out_tuser, and in out_tdata the
// slot, denomination, new count, exact amount, saturation flag and reject request.
// Each frame is parsed one character per cycle; for a well-formed tally the
// table is then searched by 4 lanes in parallel, 4 entries per step over up to
// 4 steps, and the matching or appended entry (none if the table is full) is
// updated and multiplied out.
// The next frame is taken the cycle after a result is loaded, so no new frame
// is taken while one is still in work.
// A finished result waits in the output register; while the receiver stalls the
// core still takes and processes the next frame, then holds it until the slot frees.
// Reset empties the table (the entry count goes to zero) and drops any pending result.
// A start frame empties the table the same way; an end frame sets send_reject.

module denomination_tally_table_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dtt_pkg::IN_W-1:0]        in_tdata,   // frame_length, denom_chars, pcs_chars
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dtt_pkg::OUT_W-1:0]       out_tdata,  // entry_index, denom_value,
                                                      // piece_count, entry_amount,
                                                      // count_saturated, send_reject, pad
  output logic [dtt_pkg::STATUS_W-1:0]    out_tuser   // status
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PARSE  = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_UPD    = 3'd4;
  localparam logic [2:0] S_MUL    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  localparam logic [2:0] LAST_CHAR = 3'(dtt_pkg::DENOM_CHARS - 1);
  localparam logic [2:0] PCS_START = 3'(dtt_pkg::DENOM_CHARS - dtt_pkg::PCS_CHARS);
  localparam logic [dtt_pkg::STEP_W-1:0] LAST_STEP = dtt_pkg::STEP_W'(dtt_pkg::STEPS - 1);

  // Control state.
  logic [2:0]                  state_r, state_nxt;
  logic [dtt_pkg::CNT_W-1:0]   entries_used_r, entries_used_nxt;
  logic                        out_tvalid_r, out_tvalid_nxt;
  logic                        chk_vld_r, chk_vld_nxt;

  // Working registers.
  logic [2:0]                  cnt_r, cnt_nxt;
  logic [dtt_pkg::DCH_W-1:0]   dch_r, dch_nxt;
  logic [dtt_pkg::PCH_W-1:0]   pch_r, pch_nxt;
  dtt_pkg::parse_t             dpar_r, dpar_nxt;
  dtt_pkg::parse_t             ppar_r, ppar_nxt;
  logic                        short_r, short_nxt;
  logic                        start_r, start_nxt;
  logic                        end_r, end_nxt;
  logic [dtt_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [dtt_pkg::STEP_W-1:0]  chk_step_r, chk_step_nxt;
  logic                        found_r, found_nxt;
  logic [dtt_pkg::GI_W-1:0]    slot_r, slot_nxt;
  logic [dtt_pkg::COUNT_W-1:0] ncount_r, ncount_nxt;
  logic                        sat_r, sat_nxt;
  logic [dtt_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [dtt_pkg::AMOUNT_W-1:0] amount_r, amount_nxt;
  logic [dtt_pkg::OUT_W-1:0]   out_tdata_r, out_tdata_nxt;
  logic [dtt_pkg::STATUS_W-1:0] out_tuser_r, out_tuser_nxt;

  // Datapath helpers.
  logic [dtt_pkg::DCH_W-1:0]   in_dch;
  logic [dtt_pkg::PCH_W-1:0]   in_pch;
  logic [dtt_pkg::LEN_W-1:0]   in_len;
  logic [dtt_pkg::PCS_W-1:0]   pcs_val;
  logic [dtt_pkg::COUNT_W:0]   sum;
  logic                        upd_we;
  logic [dtt_pkg::GI_W-1:0]    wr_slot;
  logic [dtt_pkg::COUNT_W-1:0] wr_count;
  logic                        tallied;

  dtt_pkg::lane_wr_t           lane_wr  [dtt_pkg::LANES];
  dtt_pkg::lane_res_t          lane_res [dtt_pkg::LANES];
  dtt_pkg::merge_res_t         mres;

  assign in_len  = in_tdata[dtt_pkg::IN_LEN_LSB +: dtt_pkg::LEN_W];
  assign in_dch  = in_tdata[dtt_pkg::IN_DCH_LSB +: dtt_pkg::DCH_W];
  assign in_pch  = in_tdata[dtt_pkg::IN_PCH_LSB +: dtt_pkg::PCH_W];
  assign pcs_val = ppar_r.acc[dtt_pkg::PCS_W-1:0];
  assign sum     = {1'b0, ncount_r} + (dtt_pkg::COUNT_W + 1)'(pcs_val);
  assign tallied = (status_r == dtt_pkg::ST_TALLIED);

  // Search lanes, each holding every LANES-th table entry.
  for (genvar l = 0; l < dtt_pkg::LANES; l++) begin : g_lane
    dtt_lane u_lane (
      .clk     (clk),
      .rd_addr (step_r),
      .key     (dpar_r.acc),
      .wr      (lane_wr[l]),
      .res     (lane_res[l])
    );
  end

  dtt_merge u_merge (
    .res          (lane_res),
    .step         (chk_step_r),
    .entries_used (entries_used_r),
    .mres         (mres)
  );

  // Steer the table write to the lane that owns the slot.
  always_comb begin
    for (int l = 0; l < dtt_pkg::LANES; l++) begin
      lane_wr[l].en    = upd_we && (wr_slot[dtt_pkg::LANE_W-1:0] == dtt_pkg::LANE_W'(l));
      lane_wr[l].addr  = wr_slot[dtt_pkg::GI_W-1:dtt_pkg::LANE_W];
      lane_wr[l].value = dpar_r.acc;
      lane_wr[l].count = wr_count;
    end
  end

  // Sequencer: parse, classify, search, update, multiply, hand over.
  always_comb begin
    state_nxt        = state_r;
    entries_used_nxt = entries_used_r;
    out_tvalid_nxt   = out_tvalid_r && !out_tready;
    chk_vld_nxt      = 1'b0;
    cnt_nxt          = cnt_r;
    dch_nxt          = dch_r;
    pch_nxt          = pch_r;
    dpar_nxt         = dpar_r;
    ppar_nxt         = ppar_r;
    short_nxt        = short_r;
    start_nxt        = start_r;
    end_nxt          = end_r;
    step_nxt         = step_r;
    chk_step_nxt     = step_r;
    found_nxt        = found_r;
    slot_nxt         = slot_r;
    ncount_nxt       = ncount_r;
    sat_nxt          = sat_r;
    status_nxt       = status_r;
    amount_nxt       = amount_r;
    out_tdata_nxt    = out_tdata_r;
    out_tuser_nxt    = out_tuser_r;
    upd_we           = 1'b0;
    wr_slot          = slot_r;
    wr_count         = ncount_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          dch_nxt   = in_dch;
          pch_nxt   = in_pch;
          short_nxt = (in_len < dtt_pkg::MIN_LEN);
          start_nxt = (in_dch == '0) && (in_pch == '0);
          end_nxt   = (&in_dch) && (&in_pch);
          dpar_nxt  = '0;
          ppar_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = S_PARSE;
        end
      end

      // One denomination character per cycle; the three count characters run alongside the last three of them.
      S_PARSE: begin
        dpar_nxt = dtt_pkg::parse_step(dpar_r, dch_r[dtt_pkg::DCH_W-1 -: 8]);
        dch_nxt  = {dch_r[dtt_pkg::DCH_W-9:0], 8'h00};
        if (cnt_r >= PCS_START) begin
          ppar_nxt = dtt_pkg::parse_step(ppar_r, pch_r[dtt_pkg::PCH_W-1 -: 8]);
          pch_nxt  = {pch_r[dtt_pkg::PCH_W-9:0], 8'h00};
        end
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == LAST_CHAR) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        sat_nxt   = 1'b0;
        state_nxt = S_OUT;
        if (short_r) begin
          status_nxt = dtt_pkg::ST_SHORT;
        end else if (start_r) begin
          entries_used_nxt = '0;
          status_nxt       = dtt_pkg::ST_START;
        end else if (end_r) begin
          status_nxt = dtt_pkg::ST_END;
        end else if (dpar_r.bad || !dpar_r.seen || ppar_r.bad || !ppar_r.seen ||
                     (dpar_r.acc == '0)) begin
          status_nxt = dtt_pkg::ST_MALFORMED;
        end else begin
          step_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end

      // Each compare checks the entries read from the address of the previous cycle.
      S_SCAN: begin
        if (step_r != LAST_STEP) begin
          step_nxt = step_r + dtt_pkg::STEP_W'(1);
        end
        if (chk_vld_r && mres.found) begin
          found_nxt  = 1'b1;
          slot_nxt   = mres.slot;
          ncount_nxt = mres.count;
          state_nxt  = S_UPD;
        end else if (chk_vld_r && (chk_step_r == LAST_STEP)) begin
          found_nxt = 1'b0;
          state_nxt = S_UPD;
        end else begin
          chk_vld_nxt = 1'b1;
        end
      end

      // Saturating add on a hit, append on a miss, full table otherwise.
      S_UPD: begin
        if (found_r) begin
          wr_count   = sum[dtt_pkg::COUNT_W] ? dtt_pkg::COUNT_MAX : sum[dtt_pkg::COUNT_W-1:0];
          upd_we     = 1'b1;
          ncount_nxt = wr_count;
          sat_nxt    = sum[dtt_pkg::COUNT_W];
          status_nxt = dtt_pkg::ST_TALLIED;
          state_nxt  = S_MUL;
        end else if (entries_used_r >= dtt_pkg::CNT_W'(dtt_pkg::MAX_ENTRIES)) begin
          status_nxt = dtt_pkg::ST_FULL;
          state_nxt  = S_OUT;
        end else begin
          wr_slot          = dtt_pkg::GI_W'(entries_used_r);
          wr_count         = dtt_pkg::COUNT_W'(pcs_val);
          upd_we           = 1'b1;
          slot_nxt         = wr_slot;
          ncount_nxt       = wr_count;
          entries_used_nxt = entries_used_r + dtt_pkg::CNT_W'(1);
          status_nxt       = dtt_pkg::ST_TALLIED;
          state_nxt        = S_MUL;
        end
      end

      S_MUL: begin
        amount_nxt = dtt_pkg::AMOUNT_W'(dpar_r.acc) * dtt_pkg::AMOUNT_W'(ncount_r);
        state_nxt  = S_OUT;
      end

      // Load the output register once it is free.
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = status_r;
          out_tdata_nxt  = {
            (dtt_pkg::OUT_W - dtt_pkg::OUT_USED)'(0),
            (status_r == dtt_pkg::ST_END),
            tallied && sat_r,
            tallied ? amount_r : dtt_pkg::AMOUNT_W'(0),
            tallied ? ncount_r : dtt_pkg::COUNT_W'(0),
            tallied ? dpar_r.acc : dtt_pkg::DENOM_W'(0),
            tallied ? dtt_pkg::INDEX_W'(slot_r) : dtt_pkg::INDEX_W'(0)
          };
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      entries_used_r <= '0;
      out_tvalid_r   <= 1'b0;
      chk_vld_r      <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      entries_used_r <= entries_used_nxt;
      out_tvalid_r   <= out_tvalid_nxt;
      chk_vld_r      <= chk_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    dch_r       <= dch_nxt;
    pch_r       <= pch_nxt;
    dpar_r      <= dpar_nxt;
    ppar_r      <= ppar_nxt;
    short_r     <= short_nxt;
    start_r     <= start_nxt;
    end_r       <= end_nxt;
    step_r      <= step_nxt;
    chk_step_r  <= chk_step_nxt;
    found_r     <= found_nxt;
    slot_r      <= slot_nxt;
    ncount_r    <= ncount_nxt;
    sat_r       <= sat_nxt;
    status_r    <= status_nxt;
    amount_r    <= amount_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== src/dtt_checker.sv =====
`timescale 1ns / 1ps
`include "denomination_tally_table_core_assert.svh"

module dtt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [dtt_pkg::OUT_W-1:0]     out_tdata,
  input logic [dtt_pkg::STATUS_W-1:0]  out_tuser
);

  // A stalled result keeps its payload.
  `DTT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // One frame at a time: an accepted request closes the input until its result is built.
  `DTT_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "input reopened right after a request")

  // Only tallied results carry entry data, and the reject request comes with an end frame alone.
  `DTT_ASSERT_NOW(a_untallied_zero, out_tvalid && (out_tuser != dtt_pkg::ST_TALLIED), out_tdata[dtt_pkg::OUT_SAT_BIT:0] == '0, "untallied result carries entry data")
  `DTT_ASSERT_NOW(a_reject_end, out_tvalid, out_tdata[dtt_pkg::OUT_REJ_BIT] == (out_tuser == dtt_pkg::ST_END), "reject request without end frame")

  // A clipped addition leaves the count at its ceiling.
  `DTT_ASSERT_NOW(a_sat_max, out_tvalid && out_tdata[dtt_pkg::OUT_SAT_BIT], out_tdata[dtt_pkg::OUT_CNT_LSB +: dtt_pkg::COUNT_W] == dtt_pkg::COUNT_MAX, "saturated count below ceiling")

endmodule

bind denomination_tally_table_core dtt_checker u_dtt_checker (.*);

// ===== dv/denomination_tally_table_core_tb.sv =====
`timescale 1ns / 1ps

module denomination_tally_table_core_tb;

  // Cycles without any accepted request, on either side, before the run is abandoned.
  localparam int STALL_LIMIT = 1000;
  // Settling time after the last result, well above the longest frame latency.
  localparam int SETTLE_CYCLES = 40;

  // One result as the table should report it.
  typedef struct {
    logic [dtt_pkg::STATUS_W-1:0] status;
    logic [dtt_pkg::INDEX_W-1:0]  index;
    logic [dtt_pkg::DENOM_W-1:0]  denom;
    logic [dtt_pkg::COUNT_W-1:0]  count;
    logic [dtt_pkg::AMOUNT_W-1:0] amount;
    logic                         saturated;
    logic                         reject;
  } tally_result_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [dtt_pkg::IN_W-1:0]     in_tdata = '0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [dtt_pkg::OUT_W-1:0]    out_tdata;
  logic [dtt_pkg::STATUS_W-1:0] out_tuser;

  // Predicted copy of the tally table.
  logic [dtt_pkg::DENOM_W-1:0] table_values [dtt_pkg::MAX_ENTRIES];
  logic [dtt_pkg::COUNT_W-1:0] table_counts [dtt_pkg::MAX_ENTRIES];
  int unsigned                 table_used = 0;
  bit                          after_end_seen = 1'b0;

  tally_result_t pending_results [$];
  int unsigned   mismatches = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   sender_idle_pct = 29;
  int unsigned   receiver_idle_pct = 47;

  denomination_tally_table_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  // Reads an ASCII decimal field, first character in the high byte. Padding may
  // lead and trail the digits, but no digit may follow trailing padding.
  function automatic bit read_decimal(input logic [63:0] field, input int nchars,
                                      output logic [31:0] value);
    logic [7:0]  ch;
    logic [31:0] acc;
    bit          seen;
    bit          trailing;
    acc = '0;
    seen = 1'b0;
    trailing = 1'b0;
    value = '0;
    for (int i = 0; i < nchars; i++) begin
      ch = field[8*(nchars-1-i) +: 8];
      if (ch >= dtt_pkg::CH_0 && ch <= dtt_pkg::CH_9) begin
        if (trailing) begin
          return 1'b0;
        end
        acc = acc * 10 + 32'(ch - dtt_pkg::CH_0);
        seen = 1'b1;
      end else if (ch == dtt_pkg::CH_SPACE || ch == dtt_pkg::CH_NUL) begin
        if (seen) begin
          trailing = 1'b1;
        end
      end else begin
        return 1'b0;
      end
    end
    value = acc;
    return seen;
  endfunction

  // Applies one frame to the predicted table and returns the result it should give.
  function automatic tally_result_t predict_tally(logic [dtt_pkg::LEN_W-1:0] len,
                                                  logic [dtt_pkg::DCH_W-1:0] dch,
                                                  logic [dtt_pkg::PCH_W-1:0] pch);
    tally_result_t r;
    logic [31:0]   denom;
    logic [31:0]   pcs;
    logic [31:0]   sum;
    logic [63:0]   product;
    bit            denom_ok;
    bit            pcs_ok;
    bit            found;
    int unsigned   slot;
    r = '{default: '0};
    if (len < dtt_pkg::MIN_LEN) begin
      r.status = dtt_pkg::ST_SHORT;
      return r;
    end
    if (dch == '0 && pch == '0) begin
      table_used = 0;
      r.status = dtt_pkg::ST_START;
      return r;
    end
    if (&dch && &pch) begin
      after_end_seen = 1'b1;
      r.status = dtt_pkg::ST_END;
      r.reject = 1'b1;
      return r;
    end
    denom_ok = read_decimal(dch, dtt_pkg::DENOM_CHARS, denom);
    pcs_ok = read_decimal(64'(pch), dtt_pkg::PCS_CHARS, pcs);
    if (!denom_ok || !pcs_ok || denom == 0) begin
      r.status = dtt_pkg::ST_MALFORMED;
      return r;
    end
    found = 1'b0;
    slot = 0;
    for (int i = 0; i < table_used; i++) begin
      if (!found && table_values[i] == denom[dtt_pkg::DENOM_W-1:0]) begin
        found = 1'b1;
        slot = i;
      end
    end
    if (found) begin
      sum = 32'(table_counts[slot]) + pcs;
      if (sum > 32'(dtt_pkg::COUNT_MAX)) begin
        r.count = dtt_pkg::COUNT_MAX;
        r.saturated = 1'b1;
      end else begin
        r.count = sum[dtt_pkg::COUNT_W-1:0];
      end
      table_counts[slot] = r.count;
    end else begin
      if (table_used >= dtt_pkg::MAX_ENTRIES) begin
        r.status = dtt_pkg::ST_FULL;
        return r;
      end
      slot = table_used;
      r.count = pcs[dtt_pkg::COUNT_W-1:0];
      table_values[slot] = denom[dtt_pkg::DENOM_W-1:0];
      table_counts[slot] = r.count;
      table_used++;
    end
    product = 64'(denom);
    product = product * 64'(r.count);
    r.status = dtt_pkg::ST_TALLIED;
    r.index = slot[dtt_pkg::INDEX_W-1:0];
    r.denom = denom[dtt_pkg::DENOM_W-1:0];
    r.amount = product[dtt_pkg::AMOUNT_W-1:0];
    return r;
  endfunction

  function automatic logic [7:0] pad_char();
    return ($urandom_range(0, 1) != 0) ? dtt_pkg::CH_SPACE : dtt_pkg::CH_NUL;
  endfunction

  // Formats a value as a well-formed field: random padding on both sides and,
  // now and then, leading zeros.
  function automatic logic [63:0] encode_decimal(int unsigned value, int nchars);
    int unsigned digits [8];
    int unsigned v;
    int          ndig;
    int          lead;
    logic [7:0]  ch;
    logic [63:0] field;
    for (int i = 0; i < 8; i++) begin
      digits[i] = 0;
    end
    v = value;
    ndig = 0;
    do begin
      digits[ndig] = v % 10;
      v = v / 10;
      ndig++;
    end while (v != 0 && ndig < nchars);
    if ($urandom_range(0, 3) == 0) begin
      ndig = ndig + $urandom_range(0, nchars - ndig);
    end
    lead = $urandom_range(0, nchars - ndig);
    field = '0;
    for (int pos = 0; pos < nchars; pos++) begin
      if (pos < lead || pos >= lead + ndig) begin
        ch = pad_char();
      end else begin
        ch = dtt_pkg::CH_0 + 8'(digits[ndig - 1 - (pos - lead)]);
      end
      field = {field[55:0], ch};
    end
    return field;
  endfunction

  // Offers one frame, waits for its request to be taken and records the result
  // it should produce.
  task automatic send_frame(logic [dtt_pkg::LEN_W-1:0] len, logic [dtt_pkg::DCH_W-1:0] dch,
                            logic [dtt_pkg::PCH_W-1:0] pch);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {pch, dch, len};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_tally(len, dch, pch));
  endtask

  // Holds the sender back until every outstanding result has been returned.
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic test_short_frames();
    send_frame(8'd0, "     100", "  1");
    send_frame(8'd14, "     100", "  1");
    send_frame(8'd14, '0, '0);
    send_frame(8'd14, '1, '1);
  endtask

  task automatic test_start_and_end();
    send_frame(8'd255, '0, '0);
    send_frame(dtt_pkg::MIN_LEN, '1, '1);
    send_frame(8'd200, '1, '1);
  endtask

  task automatic test_field_parsing();
    // Leading, trailing and mixed padding, leading zeros, field extremes.
    send_frame(dtt_pkg::MIN_LEN, "     100", "  5");
    send_frame(8'd255, "100     ", "5  ");
    send_frame(dtt_pkg::MIN_LEN, {dtt_pkg::CH_NUL, "  00100"}, {dtt_pkg::CH_NUL, "07"});
    send_frame(dtt_pkg::MIN_LEN, "99999999", "999");
    // A zero count leaves an existing entry alone and appends a new one.
    send_frame(dtt_pkg::MIN_LEN, "99999999", "000");
    send_frame(dtt_pkg::MIN_LEN, "       7", "  0");
    // Zero denomination, missing digits, digits after padding, bad characters.
    send_frame(dtt_pkg::MIN_LEN, "       0", "  3");
    send_frame(dtt_pkg::MIN_LEN, "        ", "  3");
    send_frame(dtt_pkg::MIN_LEN, "   1 2  ", "  3");
    send_frame(dtt_pkg::MIN_LEN, "   12A  ", "  3");
    send_frame(dtt_pkg::MIN_LEN, "      12", "   ");
    send_frame(dtt_pkg::MIN_LEN, "      12", "1 2");
    // Half of a start or an end pattern is just a malformed frame.
    send_frame(dtt_pkg::MIN_LEN, "      12", '1);
    send_frame(dtt_pkg::MIN_LEN, '1, "  1");
    send_frame(dtt_pkg::MIN_LEN, '0, "  1");
  endtask

  // Sessions of tallies over a pool of denominations. Small pools with large
  // counts drive entries into saturation; large pools overflow the table.
  task automatic test_tally_sessions(int unsigned frames);
    int unsigned               pool [24];
    int unsigned               pool_size;
    int unsigned               session_len;
    int unsigned               count_kind;
    int unsigned               limit;
    int unsigned               pick;
    int unsigned               pcs;
    int unsigned               sent;
    int unsigned               p;
    logic [dtt_pkg::LEN_W-1:0] len;
    logic [dtt_pkg::DCH_W-1:0] dch;
    logic [dtt_pkg::PCH_W-1:0] pch;
    sent = 0;
    while (sent < frames) begin
      if ($urandom_range(0, 9) != 0) begin
        send_frame(8'($urandom_range(15, 255)), '0, '0);
        sent++;
      end
      case ($urandom_range(0, 3))
        0: pool_size = $urandom_range(1, 2);
        1: pool_size = $urandom_range(3, 8);
        2: pool_size = $urandom_range(12, 16);
        default: pool_size = $urandom_range(17, 24);
      endcase
      for (int i = 0; i < pool_size; i++) begin
        limit = 1;
        repeat ($urandom_range(1, 8)) limit = limit * 10;
        pool[i] = $urandom_range(1, limit - 1);
      end
      if (pool_size <= 2) begin
        session_len = $urandom_range(40, 150);
        count_kind = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 2);
      end else begin
        session_len = $urandom_range(5, 60);
        count_kind = $urandom_range(0, 2);
      end
      for (int k = 0; k < session_len && sent < frames; k++) begin
        pick = $urandom_range(0, 99);
        case (count_kind)
          0: pcs = $urandom_range(900, 999);
          1: pcs = $urandom_range(0, 999);
          default: pcs = $urandom_range(0, 9);
        endcase
        len = ($urandom_range(0, 4) == 0) ? dtt_pkg::MIN_LEN : 8'($urandom_range(15, 255));
        dch = encode_decimal(pool[$urandom_range(0, pool_size - 1)], dtt_pkg::DENOM_CHARS);
        pch = dtt_pkg::PCH_W'(encode_decimal(pcs, dtt_pkg::PCS_CHARS));
        if (pick < 80) begin
          // Well-formed tally as built above.
        end else if (pick < 86) begin
          // One character of either field replaced by an arbitrary byte.
          if ($urandom_range(0, 1) != 0) begin
            p = $urandom_range(0, dtt_pkg::DENOM_CHARS - 1);
            dch[8*p +: 8] = 8'($urandom_range(0, 255));
          end else begin
            p = $urandom_range(0, dtt_pkg::PCS_CHARS - 1);
            pch[8*p +: 8] = 8'($urandom_range(0, 255));
          end
        end else if (pick < 90) begin
          len = 8'($urandom_range(0, 14));
        end else if (pick < 94) begin
          len = 8'($urandom_range(0, 255));
          dch = {$urandom, $urandom};
          pch = dtt_pkg::PCH_W'($urandom);
        end else if (pick < 96) begin
          dch = '1;
          pch = '1;
        end else begin
          dch = encode_decimal(0, dtt_pkg::DENOM_CHARS);
        end
        send_frame(len, dch, pch);
        sent++;
      end
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Result side: compare each accepted result with the oldest prediction, and
  // stall the receiver at random.
  always @(posedge clk) begin : result_check
    tally_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("result with status %0d arrived with nothing pending", out_tuser);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 64'(want.status), 64'(out_tuser));
          check_field("entry_index", 64'(want.index),
                      64'(out_tdata[dtt_pkg::OUT_IDX_LSB +: dtt_pkg::INDEX_W]));
          check_field("denom_value", 64'(want.denom),
                      64'(out_tdata[dtt_pkg::OUT_DEN_LSB +: dtt_pkg::DENOM_W]));
          check_field("piece_count", 64'(want.count),
                      64'(out_tdata[dtt_pkg::OUT_CNT_LSB +: dtt_pkg::COUNT_W]));
          check_field("entry_amount", 64'(want.amount),
                      64'(out_tdata[dtt_pkg::OUT_AMT_LSB +: dtt_pkg::AMOUNT_W]));
          check_field("count_saturated", 64'(want.saturated),
                      64'(out_tdata[dtt_pkg::OUT_SAT_BIT]));
          check_field("send_reject", 64'(want.reject),
                      64'(out_tdata[dtt_pkg::OUT_REJ_BIT]));
        end
      end
      out_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // Watchdog: abandon the run when no request moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 29;
    receiver_idle_pct = 47;
    test_short_frames();
    test_start_and_end();
    test_field_parsing();
    test_tally_sessions(440);
    wait_results_drained();

    sender_idle_pct = 47;
    receiver_idle_pct = 29;
    test_tally_sessions(440);
    wait_results_drained();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    test_tally_sessions(450);
    wait_results_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/dtt_pkg.sv
src/dtt_lane.sv
src/dtt_merge.sv
src/denomination_tally_table_core.sv
src/dtt_checker.sv
dv/denomination_tally_table_core_tb.sv
